[rtl/mcp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mcp_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_SPOT   = 3'd0;
    localparam logic [2:0] CFG_STRIKE = 3'd1;
    localparam logic [2:0] CFG_RATE   = 3'd2;
    localparam logic [2:0] CFG_VOL    = 3'd3;
    localparam logic [2:0] CFG_YEARS  = 3'd4;
    localparam logic [2:0] CFG_PATHS  = 3'd5;

    // Reset values
    localparam logic [31:0] RST_SPOT   = 32'd6553600;
    localparam logic [31:0] RST_STRIKE = 32'd6553600;
    localparam logic [19:0] RST_RATE   = 20'd3277;
    localparam logic [19:0] RST_VOL    = 20'd13107;
    localparam logic [23:0] RST_YEARS  = 24'd65536;
    localparam logic [24:0] RST_PATHS  = 25'd1024;

    // ln2 in Q.16 and exponent limits
    localparam int unsigned LN2Q    = 45426;
    localparam logic signed [35:0] XLIM_POS = 36'sd1507328;
    localparam logic signed [35:0] XLIM_NEG = -36'sd1507328;
    // bias that makes the reduced argument nonnegative: 34*ln2
    localparam logic [21:0] RED_OFFS = 22'(34 * LN2Q);
    // reciprocal of ln2q, rounded up, scaled by 2^37
    localparam logic [21:0] RED_MUL  = 22'(((64'd1 << 37) + 64'(LN2Q) - 64'd1) / 64'(LN2Q));
    localparam int unsigned RED_SH   = 37;
    localparam logic [6:0]  K_BIAS_SH = 7'd67;

    localparam logic [55:0] SUM_MAX = {56{1'b1}};

    // floor(2^32 / i) for the Taylor term divide; entry 1 is capped to 32 bits
    localparam logic [31:0] RECIP [0:32] = '{
        32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'((64'd1 << 32) / 64'd2),  32'((64'd1 << 32) / 64'd3),
        32'((64'd1 << 32) / 64'd4),  32'((64'd1 << 32) / 64'd5),
        32'((64'd1 << 32) / 64'd6),  32'((64'd1 << 32) / 64'd7),
        32'((64'd1 << 32) / 64'd8),  32'((64'd1 << 32) / 64'd9),
        32'((64'd1 << 32) / 64'd10), 32'((64'd1 << 32) / 64'd11),
        32'((64'd1 << 32) / 64'd12), 32'((64'd1 << 32) / 64'd13),
        32'((64'd1 << 32) / 64'd14), 32'((64'd1 << 32) / 64'd15),
        32'((64'd1 << 32) / 64'd16), 32'((64'd1 << 32) / 64'd17),
        32'((64'd1 << 32) / 64'd18), 32'((64'd1 << 32) / 64'd19),
        32'((64'd1 << 32) / 64'd20), 32'((64'd1 << 32) / 64'd21),
        32'((64'd1 << 32) / 64'd22), 32'((64'd1 << 32) / 64'd23),
        32'((64'd1 << 32) / 64'd24), 32'((64'd1 << 32) / 64'd25),
        32'((64'd1 << 32) / 64'd26), 32'((64'd1 << 32) / 64'd27),
        32'((64'd1 << 32) / 64'd28), 32'((64'd1 << 32) / 64'd29),
        32'((64'd1 << 32) / 64'd30), 32'((64'd1 << 32) / 64'd31),
        32'((64'd1 << 32) / 64'd32)
    };

    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic volt;
        logic diff;
        logic exp_go;
        logic exp_sel;    // 0: path price, 1: discount
        logic acc;
        logic div_go;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic exp_done;
        logic div_done;
        logic batch_end;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[rtl/mcp_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcp_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [55:0] i_dividend,
    input  wire logic [24:0] i_divisor,
    output logic             o_done,
    output logic [55:0]      o_quo
);
    logic [55:0] r_quo;
    logic [24:0] r_rem;
    logic [24:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [25:0] n_trial;
    logic        n_bit;

    assign n_trial = {r_rem, r_quo[55]};
    assign n_bit   = (n_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_bit ? 25'(n_trial - {1'b0, r_den}) : n_trial[24:0];
                r_quo <= {r_quo[54:0], n_bit};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd55) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

[rtl/mcp_exp.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcp_exp #(
    parameter int EXP_ITERATIONS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic [31:0]        i_a,
    input  wire logic signed [35:0] i_x,
    output logic                    o_done,
    output logic [31:0]             o_res
);
    import mcp_pkg::*;

    localparam int IW = $clog2(EXP_ITERATIONS + 1);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_RED  = 3'd1;
    localparam logic [2:0] E_COR  = 3'd2;
    localparam logic [2:0] E_MUL  = 3'd3;
    localparam logic [2:0] E_REC  = 3'd4;
    localparam logic [2:0] E_DIVI = 3'd5;
    localparam logic [2:0] E_FIN  = 3'd6;
    localparam logic [2:0] E_SH   = 3'd7;

    logic [2:0]  r_st;
    logic        r_done;
    logic [31:0] r_res;
    logic [31:0] r_a;
    logic [21:0] r_xo;
    logic [6:0]  r_q;
    logic [29:0] r_f30;
    logic [30:0] r_term;
    logic [31:0] r_ef;
    logic [30:0] r_t;
    logic [62:0] r_m;
    logic [63:0] r_p;
    logic [IW-1:0] r_i;

    logic [43:0] n_red;
    logic [23:0] n_rem;
    logic [60:0] n_tf;
    logic [30:0] n_q0;
    logic [30:0] n_rr;
    logic [30:0] n_qq;
    logic [66:0] n_w;

    assign n_red = r_xo * RED_MUL;
    assign n_rem = 24'(r_xo) - 24'(r_q * 22'(LN2Q));
    assign n_tf  = r_term * r_f30;
    assign n_q0  = r_m[62:32];
    assign n_rr  = r_t - 31'(n_q0 * 31'(r_i));
    assign n_qq  = (n_rr >= 31'(r_i)) ? n_q0 + 31'd1 : n_q0;
    assign n_w   = {r_p, 3'b000} >> (K_BIAS_SH - r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= E_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                E_IDLE: begin
                    if (i_go) begin
                        r_a <= i_a;
                        if (i_a == 32'd0) begin
                            r_res  <= 32'd0;
                            r_done <= 1'b1;
                        end else if (i_x >= XLIM_POS) begin
                            r_res  <= 32'hFFFF_FFFF;
                            r_done <= 1'b1;
                        end else if (i_x <= XLIM_NEG) begin
                            r_res  <= 32'd0;
                            r_done <= 1'b1;
                        end else begin
                            r_xo <= 22'(i_x) + RED_OFFS;
                            r_st <= E_RED;
                        end
                    end
                end
                E_RED: begin
                    r_q  <= 7'(n_red >> RED_SH);
                    r_st <= E_COR;
                end
                E_COR: begin
                    if (n_rem[23]) begin
                        r_q   <= r_q - 7'd1;
                        r_f30 <= {16'(n_rem + 24'(LN2Q)), 14'd0};
                    end else begin
                        r_f30 <= {n_rem[15:0], 14'd0};
                    end
                    r_term <= 31'd1 << 30;
                    r_ef   <= 32'd1 << 30;
                    r_i    <= IW'(1);
                    r_st   <= E_MUL;
                end
                E_MUL: begin
                    r_t  <= n_tf[60:30];
                    r_st <= E_REC;
                end
                E_REC: begin
                    r_m  <= r_t * RECIP[6'(r_i)];
                    r_st <= E_DIVI;
                end
                E_DIVI: begin
                    r_term <= n_qq;
                    r_ef   <= r_ef + 32'(n_qq);
                    if (r_i == IW'(EXP_ITERATIONS)) begin
                        r_st <= E_FIN;
                    end else begin
                        r_i  <= r_i + IW'(1);
                        r_st <= E_MUL;
                    end
                end
                E_FIN: begin
                    r_p  <= r_a * r_ef;
                    r_st <= E_SH;
                end
                E_SH: begin
                    r_res  <= (|n_w[66:32]) ? 32'hFFFF_FFFF : n_w[31:0];
                    r_done <= 1'b1;
                    r_st   <= E_IDLE;
                end
                default: r_st <= E_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
`default_nettype wire

[rtl/mcp_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcp_dp #(
    parameter int EXP_ITERATIONS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mcp_pkg::t_cmd i_cmd,
    output mcp_pkg::t_sts      o_sts,
    input  wire logic          i_cfg_valid,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic signed [15:0] i_shock,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic [31:0]        o_option_price,
    output logic [24:0]        o_paths_used
);
    import mcp_pkg::*;

    logic [31:0]        r_spot;
    logic [31:0]        r_strike;
    logic signed [19:0] r_rate;
    logic [19:0]        r_vol;
    logic [23:0]        r_years;
    logic [24:0]        r_npath;

    logic signed [15:0] r_z;
    logic [22:0]        r_hv2;
    logic [41:0]        r_sq_n;
    logic [41:0]        r_sq_res;
    logic [41:0]        r_sq_bit;
    logic signed [33:0] r_drift;
    logic [23:0]        r_volt;
    logic signed [35:0] r_x;
    logic signed [35:0] r_xd;
    logic [55:0]        r_sum;
    logic [24:0]        r_done_cnt;
    logic               r_out_valid;
    logic [31:0]        r_out_price;
    logic [24:0]        r_out_paths;

    logic [24:0]        n_neff;
    logic [39:0]        n_vv;
    logic [41:0]        n_sq_sum;
    logic signed [24:0] n_rmh;
    logic signed [49:0] n_dprod;
    logic [40:0]        n_vs;
    logic signed [40:0] n_vz;
    logic signed [44:0] n_rt;
    logic signed [45:0] n_nrt;
    logic [31:0]        n_payoff;
    logic [56:0]        n_sum;
    logic [31:0]        n_mean;
    logic [31:0]        n_exp_a;
    logic signed [35:0] n_exp_x;
    logic               w_exp_done;
    logic [31:0]        w_exp_res;
    logic               w_div_done;
    logic [55:0]        w_quo;

    assign n_neff   = (r_npath == 25'd0) ? 25'd1 : r_npath;
    assign n_vv     = r_vol * r_vol;
    assign n_sq_sum = r_sq_res + r_sq_bit;
    assign n_rmh    = 25'(r_rate) - $signed({2'b00, r_hv2});
    assign n_dprod  = n_rmh * $signed({1'b0, r_years});
    assign n_vs     = r_vol * r_sq_res[20:0];
    assign n_vz     = $signed({1'b0, r_volt}) * r_z;
    assign n_rt     = r_rate * $signed({1'b0, r_years});
    assign n_nrt    = -(46'(n_rt));
    assign n_payoff = (w_exp_res > r_strike) ? w_exp_res - r_strike : 32'd0;
    assign n_sum    = {1'b0, r_sum} + 57'(n_payoff);
    assign n_mean   = (|w_quo[55:32]) ? 32'hFFFF_FFFF : w_quo[31:0];
    assign n_exp_a  = i_cmd.exp_sel ? n_mean : r_spot;
    assign n_exp_x  = i_cmd.exp_sel ? r_xd : r_x;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spot   <= RST_SPOT;
            r_strike <= RST_STRIKE;
            r_rate   <= RST_RATE;
            r_vol    <= RST_VOL;
            r_years  <= RST_YEARS;
            r_npath  <= RST_PATHS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPOT:   r_spot   <= i_cfg_data;
                CFG_STRIKE: r_strike <= i_cfg_data;
                CFG_RATE:   r_rate   <= i_cfg_data[19:0];
                CFG_VOL:    r_vol    <= i_cfg_data[19:0];
                CFG_YEARS:  r_years  <= i_cfg_data[23:0];
                CFG_PATHS:  r_npath  <= i_cfg_data[24:0];
                default: ;
            endcase
        end
    end

    // per-path arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z      <= i_shock;
            r_hv2    <= n_vv[39:17];
            r_sq_n   <= {2'b00, r_years, 16'd0};
            r_sq_res <= '0;
            r_sq_bit <= 42'd1 << 40;
        end
        if (i_cmd.sqrt_step) begin
            if (r_sq_n >= n_sq_sum) begin
                r_sq_n   <= r_sq_n - n_sq_sum;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
            r_drift  <= 34'(n_dprod >>> 16);
        end
        if (i_cmd.volt) begin
            r_volt <= n_vs[39:16];
        end
        if (i_cmd.diff) begin
            r_x <= 36'(r_drift) + 36'(n_vz >>> 12);
        end
        if (i_cmd.acc) begin
            r_xd <= 36'(n_nrt >>> 16);
        end
    end

    // accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_done_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.acc) begin
                r_sum      <= n_sum[56] ? SUM_MAX : n_sum[55:0];
                r_done_cnt <= r_done_cnt + 25'd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_out_price <= w_exp_res;
                r_out_paths <= n_neff;
                r_sum       <= '0;
                r_done_cnt  <= '0;
            end
        end
    end

    mcp_exp #(.EXP_ITERATIONS(EXP_ITERATIONS)) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.exp_go),
        .i_a     (n_exp_a),
        .i_x     (n_exp_x),
        .o_done  (w_exp_done),
        .o_res   (w_exp_res)
    );

    mcp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (r_sum),
        .i_divisor  (n_neff),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    assign o_sts.exp_done  = w_exp_done;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.batch_end = (r_done_cnt >= n_neff);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_option_price = r_out_price;
    assign o_paths_used   = r_out_paths;
endmodule
`default_nettype wire

[rtl/mcp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire mcp_pkg::t_sts i_sts,
    output mcp_pkg::t_cmd      o_cmd
);
    import mcp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQRT  = 4'd1;
    localparam logic [3:0] S_VOLT  = 4'd2;
    localparam logic [3:0] S_DIFF  = 4'd3;
    localparam logic [3:0] S_EXP1  = 4'd4;
    localparam logic [3:0] S_EXP1W = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DIVW  = 4'd9;
    localparam logic [3:0] S_EXP2  = 4'd10;
    localparam logic [3:0] S_EXP2W = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] r_st;
    logic [3:0] n_st;
    logic [4:0] r_cnt;

    always_comb begin
        o_cmd = '0;
        n_st  = r_st;
        unique case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_st       = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == 5'd20) begin
                    n_st = S_VOLT;
                end
            end
            S_VOLT: begin
                o_cmd.volt = 1'b1;
                n_st       = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_st       = S_EXP1;
            end
            S_EXP1: begin
                o_cmd.exp_go = 1'b1;
                n_st         = S_EXP1W;
            end
            S_EXP1W: begin
                if (i_sts.exp_done) begin
                    n_st = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_st      = S_CHK;
            end
            S_CHK: begin
                n_st = i_sts.batch_end ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_go = 1'b1;
                n_st         = S_DIVW;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    n_st = S_EXP2;
                end
            end
            S_EXP2: begin
                o_cmd.exp_go  = 1'b1;
                o_cmd.exp_sel = 1'b1;
                n_st          = S_EXP2W;
            end
            S_EXP2W: begin
                if (i_sts.exp_done) begin
                    n_st = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_st           = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_cnt <= (r_st == S_SQRT) ? r_cnt + 5'd1 : 5'd0;
        end
    end

    assign o_in_stall = (r_st != S_IDLE);
endmodule
`default_nettype wire

[rtl/monte_carlo_call_pricer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Monte Carlo European call pricer, fixed point.
// Input channel (i_in_valid / o_in_stall) carries one word per path: a signed
// Q4.12 normal shock. Each word is priced as S*exp(drift + vol*sqrt(T)*z),
// the call payoff is added to a 56-bit saturating sum, and after path_count
// words one result word (Q16.16 discounted mean, paths used) is sent on the
// output channel (o_out_valid / i_out_stall).
// Config port (i_cfg_valid / o_cfg_ready, always ready) writes the six
// registers by index; write only while the block is idle.
// Per path: accept, bitwise square root (one step a cycle), volatility
// scaling and diffusion, the Taylor exponential (multiply / reciprocal /
// correct per term), accumulate and batch check. o_in_stall stays high
// after the accepting edge until the block is back in idle. The last path
// of a batch also runs the restoring divider (start, 56 steps, done), the
// discount exponential (which skips the series when the mean is zero) and
// the load of the result register.
// Result words sit in an output register; a new batch may start while one
// waits, and a finished batch holds until the register is free.
// Reset (synchronous, active low) restores register defaults and clears the
// sum, the path counter and the output valid.
module monte_carlo_call_pricer #(
    parameter int EXP_ITERATIONS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_shock,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [31:0]             o_option_price,
    output logic [24:0]             o_paths_used,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import mcp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // registers may be written whenever the block is idle
    assign o_cfg_ready = 1'b1;

    mcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mcp_dp #(.EXP_ITERATIONS(EXP_ITERATIONS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_shock        (i_shock),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_option_price (o_option_price),
        .o_paths_used   (o_paths_used)
    );
endmodule
`default_nettype wire

[rtl/mcp_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcp_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_option_price,
    input wire logic [24:0] o_paths_used
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_option_price) && $stable(o_paths_used)))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled while a path is in work");

    a_paths_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_paths_used != 25'd0))
        else $error("result word with zero paths");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
endmodule

bind monte_carlo_call_pricer mcp_chk u_mcp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_option_price (o_option_price),
    .o_paths_used   (o_paths_used)
);
`default_nettype wire

[tb/monte_carlo_call_pricer_tb.sv]
`timescale 1ns / 1ps
module monte_carlo_call_pricer_tb;
    import mcp_pkg::*;

    localparam int     EXP_ITER   = 16;
    localparam longint LN2_Q16    = 45426;
    localparam longint X_SAT      = 23 * 65536;
    localparam longint unsigned PAYOFF_SUM_MAX = (64'd1 << 56) - 64'd1;
    localparam int     SETTLE_CYC = 400;      // one path plus divide plus discount, with margin
    localparam int     HOLD_LEN   = 3000;     // long receiver hold-off
    localparam longint CYCLE_LIMIT = 4000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic signed [15:0] i_shock = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    wire                o_in_stall;
    wire                o_out_valid;
    wire [31:0]         o_option_price;
    wire [24:0]         o_paths_used;
    wire                o_cfg_ready;

    monte_carlo_call_pricer #(.EXP_ITERATIONS(EXP_ITER)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_shock(i_shock),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_option_price(o_option_price), .o_paths_used(o_paths_used),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Pricing model: shadow registers and batch state
    // ---------------------------------------------------------------
    typedef struct {
        logic [31:0] price;
        logic [24:0] paths;
    } t_price_word;

    t_price_word    pending_prices[$];

    logic [31:0]    m_spot, m_strike;
    longint         m_rate;               // signed Q4.16
    longint         m_vol, m_years;
    logic [24:0]    m_path_count;
    longint unsigned m_payoff_sum;
    logic [24:0]    m_paths_done;

    int  err_count = 0;
    int  shocks_sent = 0;
    int  prices_checked = 0;
    int  cfg_writes = 0;
    longint cycle_count = 0;

    // burst / gap shaping for the shock sender
    int  burst_left = 0;
    // receiver stall pattern
    int  stall_mode = 0;
    int  mode_cnt = 0;
    logic long_hold = 1'b0;
    int  hold_cnt = 0;

    function automatic longint unsigned bit_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 40;
        for (int i = 0; i < 21; i++) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // a * e^x, x in Q.16, a in Q16.16
    function automatic logic [31:0] scale_by_exp(logic [31:0] a, longint x);
        longint k, f, sh;
        longint unsigned f30, term, ef, p, r;
        int s;
        if (a == 0) return 32'd0;
        if (x >= X_SAT) return 32'hFFFF_FFFF;
        if (x <= -X_SAT) return 32'd0;
        k = (x >= 0) ? x / LN2_Q16 : -((-x + LN2_Q16 - 1) / LN2_Q16);
        f = x - k * LN2_Q16;
        f30 = longint'(f) << 14;
        term = 64'd1 << 30;
        ef = term;
        for (int i = 1; i <= EXP_ITER; i++) begin
            term = ((term * f30) >> 30) / longint'(i);
            ef += term;
        end
        p = longint'(a) * ef;
        if (k >= 30) begin
            s = int'(k - 30);
            if (p >= (64'd1 << (62 - s))) return 32'hFFFF_FFFF;
            r = (p << s) >> 30;
            return r[31:0];
        end
        sh = 30 - k;
        if (sh >= 64) return 32'd0;
        r = p >> sh;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    // Accumulate one path; queue a price word when the batch closes.
    task automatic price_path(logic signed [15:0] z_in);
        longint z, half_v2, drift, vol_t, diffusion, xd;
        longint unsigned sqrt_t, mean, n;
        logic [31:0] price, payoff;
        t_price_word w;
        z = z_in;
        half_v2 = (m_vol * m_vol) >>> 17;
        drift = ((m_rate - half_v2) * m_years) >>> 16;
        sqrt_t = bit_sqrt(longint'(m_years) << 16);
        vol_t = longint'((m_vol * sqrt_t) >> 16);
        diffusion = (vol_t * z) >>> 12;
        price = scale_by_exp(m_spot, drift + diffusion);
        payoff = (price > m_strike) ? price - m_strike : 32'd0;
        n = (m_path_count == 0) ? 1 : m_path_count;
        m_payoff_sum += payoff;
        if (m_payoff_sum > PAYOFF_SUM_MAX) m_payoff_sum = PAYOFF_SUM_MAX;
        m_paths_done = m_paths_done + 25'd1;
        if (longint'(m_paths_done) < n) return;
        mean = m_payoff_sum / n;
        if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
        xd = (-(m_rate * m_years)) >>> 16;
        w.price = scale_by_exp(mean[31:0], xd);
        w.paths = n[24:0];
        pending_prices.push_back(w);
        m_payoff_sum = 0;
        m_paths_done = 0;
    endtask

    // ---------------------------------------------------------------
    // Driver side
    // ---------------------------------------------------------------
    task automatic send_shock(logic signed [15:0] z);
        i_in_valid <= 1'b1;
        i_shock <= z;
        do @(posedge i_clk); while (o_in_stall);
        price_path(z);
        shocks_sent++;
        // sender bursts: sometimes drop valid for a random gap
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
    endtask

    task automatic stop_shocks();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // block is idle: nothing expected and any result-less path has finished
    task automatic wait_idle();
        stop_shocks();
        while (pending_prices.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
        case (idx)
            CFG_SPOT:   m_spot = data;
            CFG_STRIKE: m_strike = data;
            CFG_RATE:   m_rate = longint'($signed(data[19:0]));
            CFG_VOL:    m_vol = data[19:0];
            CFG_YEARS:  m_years = data[23:0];
            CFG_PATHS:  m_path_count = data[24:0];
            default: ;  // unmapped index, ignored by the block
        endcase
    endtask

    task automatic write_all(logic [31:0] s, logic [31:0] k, logic [19:0] r,
                             logic [19:0] v, logic [23:0] t, logic [24:0] n);
        write_reg(CFG_SPOT, s);
        write_reg(CFG_STRIKE, k);
        write_reg(CFG_RATE, {12'd0, r});
        write_reg(CFG_VOL, {12'd0, v});
        write_reg(CFG_YEARS, {8'd0, t});
        write_reg(CFG_PATHS, {7'd0, n});
    endtask

    function automatic logic signed [15:0] rand_shock();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 16384)) - 8192);   // about +-2 sigma
    endfunction

    // ---------------------------------------------------------------
    // Receiver: stall pattern, long hold-off and result checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (long_hold) begin
            i_out_stall <= 1'b1;
            if (hold_cnt == HOLD_LEN - 1) begin
                long_hold <= 1'b0;
                hold_cnt <= 0;
            end else begin
                hold_cnt <= hold_cnt + 1;
            end
        end else begin
            if (mode_cnt == 150) begin
                mode_cnt <= 0;
                stall_mode <= $urandom_range(0, 3);
            end else begin
                mode_cnt <= mode_cnt + 1;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 1) == 0);
                2: i_out_stall <= ($urandom_range(0, 7) != 0);
                default: i_out_stall <= mode_cnt[4];
            endcase
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (word %0d)",
                 what, got, want, prices_checked);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_price_word w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_prices.size() == 0) begin
                report_mismatch("unexpected word, price", o_option_price, -1);
            end else begin
                w = pending_prices.pop_front();
                if (o_option_price !== w.price)
                    report_mismatch("option_price", o_option_price, w.price);
                if (o_paths_used !== w.paths)
                    report_mismatch("paths_used", o_paths_used, w.paths);
            end
            prices_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // reset registers, one path per price; shock extremes and every bit
    task automatic test_shock_extremes();
        logic signed [15:0] dir[$] = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh0001,
                                      -16'sh0001, 16'sh1000, -16'sh1000, 16'sh5555,
                                      -16'sh5556, 16'sh2AAA};
        write_reg(CFG_PATHS, 32'd1);
        foreach (dir[i]) send_shock(dir[i]);
        wait_idle();
    endtask

    // register extremes, zero path count, unmapped indexes
    task automatic test_reg_extremes();
        write_all(32'hFFFF_FFFF, 32'd0, 20'h7FFFF, 20'hFFFFF, 24'hFFFFFF, 25'd0);
        send_shock(16'sh0000);
        send_shock(-16'sh8000);
        wait_idle();
        write_all(32'd0, 32'hFFFF_FFFF, 20'h80000, 20'd0, 24'd0, 25'd2);
        repeat (4) send_shock(rand_shock());
        wait_idle();
        // unmapped indexes must not disturb anything
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h1234_5678);
        write_all(32'd200 << 16, 32'd50 << 16, 20'h80000, 20'd65536, 24'd1 << 20, 25'd1);
        send_shock(16'sh7FFF);
        send_shock(-16'sh8000);
        wait_idle();
    endtask

    // count lowered mid-batch, count at the 25-bit register maximum
    task automatic test_count_changes();
        write_all(32'd100 << 16, 32'd90 << 16, 20'd3277, 20'd13107, 24'd65536, 25'd10);
        repeat (5) send_shock(rand_shock());
        wait_idle();
        write_reg(CFG_PATHS, 32'd3);            // already past: next path closes
        send_shock(rand_shock());
        wait_idle();
        write_reg(CFG_PATHS, 32'h1FF_FFFF);
        repeat (3) send_shock(rand_shock());
        wait_idle();
        write_reg(CFG_PATHS, 32'd2);
        send_shock(rand_shock());
        wait_idle();
    endtask

    // receiver holds off while paths pile up; then sender pauses to drain
    task automatic test_backpressure();
        write_reg(CFG_PATHS, 32'd1);
        long_hold <= 1'b1;
        repeat (20) send_shock(rand_shock());
        wait_idle();
    endtask

    task automatic test_random(int n_phases, int per_phase);
        for (int p = 0; p < n_phases; p++) begin
            if ($urandom_range(0, 4) == 0) begin
                write_all($urandom, $urandom, 20'($urandom), 20'($urandom),
                          24'($urandom), 25'($urandom_range(0, 6)));
            end else begin
                write_all($urandom_range(1 << 16, 300 << 16),
                          $urandom_range(0, 300 << 16),
                          20'(int'($urandom_range(0, 20000)) - 4000),
                          20'($urandom_range(0, 50000)),
                          24'($urandom_range(0, 5 << 16)),
                          25'($urandom_range(1, 8)));
            end
            repeat (per_phase) send_shock(rand_shock());
            wait_idle();
        end
    endtask

    initial begin
        m_spot = RST_SPOT;
        m_strike = RST_STRIKE;
        m_rate = longint'($signed(RST_RATE));
        m_vol = RST_VOL;
        m_years = RST_YEARS;
        m_path_count = RST_PATHS;
        m_payoff_sum = 0;
        m_paths_done = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_shock_extremes();
        test_reg_extremes();
        test_count_changes();
        test_backpressure();
        test_random(13, 150);

        $display("covered %0d shocks, %0d price words, %0d register writes",
                 shocks_sent, prices_checked, cfg_writes);
        $display("register extremes, partial batches and output hold-off included");
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mcp_pkg.sv
rtl/mcp_div.sv
rtl/mcp_exp.sv
rtl/mcp_dp.sv
rtl/mcp_ctrl.sv
rtl/monte_carlo_call_pricer.sv
rtl/mcp_chk.sv
tb/monte_carlo_call_pricer_tb.sv
